FILE: rtl/rfab_pkg.sv
package rfab_pkg;

    localparam int CH_W  = 8;
    localparam int PIX_W = 4 * CH_W;
    localparam int ACC_W = 2 * CH_W;

    // Request kinds carried on the input tuser.
    localparam logic [1:0] REQ_PLOT = 2'd0;
    localparam logic [1:0] REQ_READ = 2'd1;
    localparam logic [1:0] REQ_FILL = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_ACTIVE_WIDTH  = 1'b0;
    localparam logic CFG_ACTIVE_HEIGHT = 1'b1;

    localparam logic [8:0] CFG_DIM_RESET = 9'd256;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic load;
        logic accum;
    } mac_ctrl_t;

endpackage

FILE: rtl/rgba_framebuffer_alpha_blend.sv
// RGBA frame store with alpha-blended plotting. Requests arrive on the slave stream with the
// kind in tuser (plot, read, fill); each request returns exactly one result on the master
// stream, zero colour and a clear inside flag unless a plot or read hit the active area.
// A request occupies the block until its result is handed to the output register. A plot
// mixes on one shared 8x8 multiply-accumulate, a load step and an accumulate step per
// channel, then writes the pixel back; a fill writes one pixel per cycle through the single
// port of the frame memory. The frame holds garbage after reset; fill it before plotting
// or reading. Write the active size only while no request is in flight.
module rgba_framebuffer_alpha_blend #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // x_coord[15:0], y_coord[31:16], in_red[39:32], in_green[47:40], in_blue[55:48],
    // in_alpha[63:56]
    input  logic [63:0] s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
    output logic [31:0] m_axis_tdata,
    // inside_res[0]
    output logic        m_axis_tuser,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_wdata
);

    import rfab_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH + 1);
    localparam int YW    = $clog2(MAX_HEIGHT + 1);
    localparam int PW    = XW + YW;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADDR  = 4'd1;
    localparam logic [3:0] S_ADDR2 = 4'd2;
    localparam logic [3:0] S_READ  = 4'd3;
    localparam logic [3:0] S_DATA  = 4'd4;
    localparam logic [3:0] S_MIX   = 4'd5;
    localparam logic [3:0] S_WRITE = 4'd6;
    localparam logic [3:0] S_FILL  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [8:0]       width_reg, height_reg;
    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_data_reg;
    logic             out_inside_reg;

    logic [1:0]       req_reg;
    logic [15:0]      x_reg, y_reg;
    logic [PIX_W-1:0] colour_reg;
    logic [PW-1:0]    prod_reg, prod_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic             inside_reg, inside_next;
    logic [PIX_W-1:0] old_reg, old_next;
    logic [PIX_W-1:0] res_reg, res_next;
    logic [1:0]       chan_reg, chan_next;
    logic             phase_reg, phase_next;
    logic [AW-1:0]    fill_idx_reg, fill_idx_next;

    logic [XW-1:0]    eff_w;
    logic [YW-1:0]    eff_h;
    logic             in_accept;
    logic             out_load;
    logic             fill_last;
    logic [1:0]       prev_chan;
    logic [CH_W-1:0]  chan_colour;

    mac_ctrl_t        mac_ctrl;
    logic [CH_W-1:0]  mac_a, mac_b, mac_quot;

    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [PIX_W-1:0] ram_wdata, ram_rdata;

    assign eff_w = (32'(width_reg) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(width_reg);
    assign eff_h = (32'(height_reg) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(height_reg);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);
    assign fill_last     = (PW'(fill_idx_reg) + PW'(1)) == prod_reg;
    assign prev_chan     = chan_reg - 2'd1;

    // Alpha blends like a colour channel whose source value is full scale.
    assign chan_colour = (chan_reg == 2'd3) ? 8'hFF : colour_reg[{chan_reg, 3'b000} +: CH_W];

    always_comb
    begin
        state_next    = state_reg;
        prod_next     = prod_reg;
        addr_next     = addr_reg;
        inside_next   = inside_reg;
        old_next      = old_reg;
        res_next      = res_reg;
        chan_next     = chan_reg;
        phase_next    = phase_reg;
        fill_idx_next = fill_idx_reg;
        mac_ctrl      = '0;
        mac_a         = chan_colour;
        mac_b         = colour_reg[31:24];
        ram_we        = 1'b0;
        ram_addr      = addr_reg;
        ram_wdata     = colour_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_next      = '0;
                    fill_idx_next = '0;
                    state_next    = S_ADDR;
                end
            end
            S_ADDR:
            begin
                if (req_reg == REQ_FILL)
                begin
                    prod_next = PW'(eff_h) * PW'(eff_w);
                end
                else
                begin
                    prod_next = PW'(y_reg[YW-1:0]) * PW'(eff_w);
                end
                inside_next = ((req_reg == REQ_PLOT) || (req_reg == REQ_READ)) &&
                              !x_reg[15] && !y_reg[15] &&
                              (32'(x_reg[14:0]) < 32'(eff_w)) &&
                              (32'(y_reg[14:0]) < 32'(eff_h));
                state_next  = S_ADDR2;
            end
            S_ADDR2:
            begin
                addr_next = AW'(prod_reg + PW'(x_reg[XW-1:0]));
                if (req_reg == REQ_FILL)
                begin
                    state_next = (prod_reg == '0) ? S_DONE : S_FILL;
                end
                else if (inside_reg)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                state_next = S_DATA;
            end
            S_DATA:
            begin
                old_next = ram_rdata;
                if (req_reg == REQ_READ)
                begin
                    res_next   = ram_rdata;
                    state_next = S_DONE;
                end
                else
                begin
                    chan_next  = 2'd0;
                    phase_next = 1'b0;
                    state_next = S_MIX;
                end
            end
            S_MIX:
            begin
                if (!phase_reg)
                begin
                    mac_ctrl.load = 1'b1;
                    // The previous channel's quotient is ready now.
                    if (chan_reg != 2'd0)
                    begin
                        res_next[{prev_chan, 3'b000} +: CH_W] = mac_quot;
                    end
                end
                else
                begin
                    mac_ctrl.accum = 1'b1;
                    mac_a          = old_reg[{chan_reg, 3'b000} +: CH_W];
                    mac_b          = ~colour_reg[31:24];
                    chan_next      = chan_reg + 2'd1;
                    if (chan_reg == 2'd3)
                    begin
                        state_next = S_WRITE;
                    end
                end
                phase_next = !phase_reg;
            end
            S_WRITE:
            begin
                ram_we           = 1'b1;
                ram_wdata        = {mac_quot, res_reg[23:0]};
                res_next[31:24]  = mac_quot;
                state_next       = S_DONE;
            end
            S_FILL:
            begin
                ram_we        = 1'b1;
                ram_addr      = fill_idx_reg;
                fill_idx_next = fill_idx_reg + AW'(1);
                if (fill_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            width_reg     <= CFG_DIM_RESET;
            height_reg    <= CFG_DIM_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && (cfg_index == CFG_ACTIVE_WIDTH))
            begin
                width_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == CFG_ACTIVE_HEIGHT))
            begin
                height_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_reg    <= s_axis_tuser;
            x_reg      <= s_axis_tdata[15:0];
            y_reg      <= s_axis_tdata[31:16];
            colour_reg <= s_axis_tdata[63:32];
        end
        prod_reg     <= prod_next;
        addr_reg     <= addr_next;
        inside_reg   <= inside_next;
        old_reg      <= old_next;
        res_reg      <= res_next;
        chan_reg     <= chan_next;
        phase_reg    <= phase_next;
        fill_idx_reg <= fill_idx_next;
        if (out_load)
        begin
            out_data_reg   <= res_reg;
            out_inside_reg <= inside_reg && (req_reg != REQ_FILL);
        end
    end

    rfab_mix u_mix (
        .clk  (clk),
        .ctrl (mac_ctrl),
        .op_a (mac_a),
        .op_b (mac_b),
        .quot (mac_quot)
    );

    rfab_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_inside_reg;

    // A taken request keeps the block busy in the cycle that follows.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("request accepted while a previous one is in flight");

    // The fill walk never passes the last pixel of the active area.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> (PW'(fill_idx_reg) < prod_reg))
        else $error("fill index beyond active area");

    // A pixel is only fetched for a point that passed clipping.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (inside_reg && (32'(addr_reg) < DEPTH)))
        else $error("frame read outside active area");

    // Only plot and read results may carry the inside flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && inside_reg) |-> ((req_reg == REQ_PLOT) || (req_reg == REQ_READ)))
        else $error("inside flag on a fill or unused request");

endmodule

FILE: rtl/rfab_ram.sv
module rfab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                            wdata,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rfab_mix.sv
module rfab_mix (
    input  logic                clk,
    input  rfab_pkg::mac_ctrl_t ctrl,
    input  logic [7:0]          op_a,
    input  logic [7:0]          op_b,
    output logic [7:0]          quot
);

    import rfab_pkg::*;

    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [ACC_W-1:0] product;
    logic [ACC_W:0]   div_sum;

    assign product = ACC_W'(op_a) * ACC_W'(op_b);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.load)
        begin
            acc_next = product;
        end
        else if (ctrl.accum)
        begin
            acc_next = acc_reg + product;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Exact floor(x / 255) for x up to 255 * 255, the largest blend sum: (x + (x >> 8) + 1) >> 8.
    assign div_sum = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(acc_reg >> CH_W) + (ACC_W+1)'(1);
    assign quot    = div_sum[ACC_W-1:CH_W];

endmodule
